// ----- rtl/core/tkdq_pkg.sv -----
`default_nettype none

package tkdq_pkg;

	localparam int unsigned COORD_W = 12;
	localparam int unsigned THR_W   = 8;
	localparam int unsigned PEND_W  = 4;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [THR_W-1:0]   thr_t;
	typedef logic [PEND_W-1:0]  pend_t;

	// Threshold after reset, and the ceiling of the run counter.
	localparam thr_t THR_RESET = 8'd4;
	localparam thr_t CNT_MAX   = 8'd255;

	// One tick as it arrives on the input channel.
	typedef struct packed {
		logic   touched;
		coord_t touch_x;
		coord_t touch_y;
		logic   pop_req;
	} tick_t;

	// One result as it leaves on the output channel.
	typedef struct packed {
		logic   event_valid;
		coord_t event_x;
		coord_t event_y;
		pend_t  pending;
	} event_t;

	// Control handed from the top level to the debouncer and the queue.
	typedef struct packed {
		logic  adv;
		tick_t tick;
	} stage_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/tkdq_chan_if.sv -----
`default_nettype none

interface tkdq_chan_if #(
	parameter type T = logic
) ();

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/tkdq_ram.sv -----
`default_nettype none

module tkdq_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 8,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/tkdq_debounce.sv -----
`default_nettype none

module tkdq_debounce import tkdq_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire stage_ctl_t ctl,
	input  wire thr_t       thr,
	input  wire logic       full,
	output logic            push
);

	localparam logic PH_PRESS   = 1'b0;
	localparam logic PH_RELEASE = 1'b1;

	logic phase_q;
	thr_t cnt_q;
	thr_t cnt_inc;
	logic reached;

	// A zero threshold is met by the first qualifying tick, as the count is at least one.
	assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 8'd1;
	assign reached = (cnt_inc >= thr);
	assign push    = ctl.adv && (phase_q == PH_PRESS) && ctl.tick.touched && reached && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PRESS;
			cnt_q   <= '0;
		end else if (ctl.adv) begin
			case (phase_q)
				PH_PRESS: begin
					if (!ctl.tick.touched) begin
						cnt_q <= '0;
					end else if (reached) begin
						// A press that finds the queue full is dropped.
						cnt_q <= '0;
						if (!full) begin
							phase_q <= PH_RELEASE;
						end
					end else begin
						cnt_q <= cnt_inc;
					end
				end
				PH_RELEASE: begin
					if (ctl.tick.touched) begin
						cnt_q <= '0;
					end else if (reached) begin
						cnt_q   <= '0;
						phase_q <= PH_PRESS;
					end else begin
						cnt_q <= cnt_inc;
					end
				end
				default: begin
					phase_q <= PH_PRESS;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	a_push_arms_release: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (phase_q == PH_RELEASE) && (cnt_q == '0))
		else $error("push did not move the debouncer to the release phase");

	a_release_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.adv && (phase_q == PH_RELEASE) && !ctl.tick.touched && reached
		|=> (phase_q == PH_PRESS) && (cnt_q == '0))
		else $error("accepted release did not return to the press phase");

endmodule

`default_nettype wire

// ----- rtl/core/tkdq_queue.sv -----
`default_nettype none

module tkdq_queue import tkdq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire stage_ctl_t ctl,
	input  wire logic       push,
	output logic            full,
	output event_t          result
);

	localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned DATA_W = 2 * COORD_W;

	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_mid;
	logic [FILL_W-1:0] fill_nxt;
	logic              pop_ok;
	logic              bypass;
	logic [DATA_W-1:0] rdata;

	logic   ev_s2;
	logic   byp_s2;
	coord_t byp_x_s2;
	coord_t byp_y_s2;
	pend_t  pend_s2;

	// The push of a tick lands before its pop, so a pop may take the entry just written.
	assign full     = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign fill_mid = fill_q + FILL_W'(push);
	assign pop_ok   = ctl.adv && ctl.tick.pop_req && (fill_mid != '0);
	assign fill_nxt = fill_mid - FILL_W'(pop_ok);
	// When the queue was empty, the popped entry is the one written in this cycle.
	assign bypass   = push && pop_ok && (fill_q == '0);

	tkdq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (push),
		.waddr (wr_ptr_q),
		.wdata ({ctl.tick.touch_x, ctl.tick.touch_y}),
		.re    (pop_ok),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			ev_s2    <= 1'b0;
			byp_s2   <= 1'b0;
		end else if (ctl.adv) begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			fill_q <= fill_nxt;
			ev_s2  <= pop_ok;
			byp_s2 <= bypass;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			byp_x_s2 <= ctl.tick.touch_x;
			byp_y_s2 <= ctl.tick.touch_y;
			pend_s2  <= PEND_W'(fill_nxt);
		end
	end

	always_comb begin
		result.event_valid = ev_s2;
		result.pending     = pend_s2;
		result.event_x     = '0;
		result.event_y     = '0;
		if (ev_s2) begin
			if (byp_s2) begin
				result.event_x = byp_x_s2;
				result.event_y = byp_y_s2;
			end else begin
				result.event_x = rdata[DATA_W-1:COORD_W];
				result.event_y = rdata[COORD_W-1:0];
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(QUEUE_DEPTH))
		else $error("queue fill count above depth");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.adv |=> $stable(fill_q) && $stable(wr_ptr_q) && $stable(rd_ptr_q))
		else $error("queue state moved without an advancing item");

	a_push_only_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop_ok |=> fill_q == FILL_W'($past(fill_q) + FILL_W'(1)))
		else $error("push without pop did not grow the fill count by one");

endmodule

`default_nettype wire

// ----- rtl/core/touch_key_debounce_queue.sv -----
`default_nettype none

// Channel  Role    Payload                                   Accepted when
// tick     sink    touched, touch_x, touch_y, pop_req        tick.valid && tick.ready
// evt      source  event_valid, event_x, event_y, pending    evt.valid && evt.ready
// cfg      sink    debounce_ticks (8 bits)                   cfg.valid && cfg.ready
//
// Every accepted tick yields exactly one result item, which passes through the input register
// and then the result stage.
// One item per cycle is sustained while the output is not stalled; the debounce counter, the queue
// pointers and the single write and read port of the event store update only as an item advances.
// Reset is asynchronous and active low; it clears the debouncer, the queue pointers
// and fill count, and sets the threshold to four. The event store is not cleared.
// A stalled output holds its result; the input register then fills and tick.ready drops.
// Configuration writes are always accepted.

module touch_key_debounce_queue import tkdq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tkdq_chan_if.sink   tick,
	tkdq_chan_if.source evt,
	tkdq_chan_if.sink   cfg
);

	thr_t       thr_q;
	logic       valid_s1;
	tick_t      item_s1;
	logic       out_valid_q;
	logic       s2_free;
	stage_ctl_t ctl;
	logic       push;
	logic       full;
	event_t     result;

	// The threshold register takes a write in any cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg.valid) begin
			thr_q <= cfg.data;
		end
	end

	// The input register advances into the result stage whenever that stage is empty
	// or its item is being taken in the same cycle.
	assign s2_free    = !out_valid_q || evt.ready;
	assign ctl.adv    = valid_s1 && s2_free;
	assign ctl.tick   = item_s1;
	assign tick.ready = !valid_s1 || ctl.adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick.valid && tick.ready) begin
				valid_s1 <= 1'b1;
			end else if (ctl.adv) begin
				valid_s1 <= 1'b0;
			end
			if (ctl.adv) begin
				out_valid_q <= 1'b1;
			end else if (evt.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			item_s1 <= tick.data;
		end
	end

	// The debouncer decides the push; the queue then applies the push before the pop.
	tkdq_debounce u_debounce (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.thr    (thr_q),
		.full   (full),
		.push   (push)
	);

	tkdq_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.push   (push),
		.full   (full),
		.result (result)
	);

	assign evt.valid = out_valid_q;
	assign evt.data  = result;

endmodule

`default_nettype wire
